// ----- design/bicubic_line_resampler_defines.svh -----
// Assertion macros for the line resampler; clk and rst are taken from the
// scope of the module that uses them.
`ifndef BICUBIC_LINE_RESAMPLER_DEFINES_SVH
`define BICUBIC_LINE_RESAMPLER_DEFINES_SVH

`define BLR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define BLR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/blr_pkg.sv -----
`timescale 1ns / 1ps

package blr_pkg;

  localparam int MAX_ROW       = 4096;
  localparam int MAX_DOWNSCALE = 4;
  localparam int MAX_UPSCALE   = 8;
  localparam int WEIGHT_BITS   = 22;
  localparam int TAP_MAX       = 4 * MAX_DOWNSCALE + 2;
  localparam int RESULT_MAX    = 32;

  localparam int ADDR_W  = $clog2(MAX_ROW);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int TAP_W   = $clog2(TAP_MAX);
  localparam int EMIT_W  = $clog2(RESULT_MAX) + 1;
  localparam int STEP_W  = 20;
  localparam int PIX_W   = 24;
  localparam int DIV_NW  = 48;
  localparam int DIV_DW  = 32;
  localparam int W_W     = 25;
  localparam int TOT_W   = 28;
  localparam int WN_W    = 49;
  localparam int ACC_W   = 64;
  localparam int T_W     = 17;
  localparam int UNIT_SCALE = 65536;
  localparam int KERN_SHIFT = 49 - WEIGHT_BITS;

  localparam logic REG_SRC_WIDTH = 1'b0;
  localparam logic REG_DST_WIDTH = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] numer;
    logic [DIV_DW-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic           start;
    logic           big;
    logic [T_W-1:0] t;
  } kern_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [W_W-1:0] w;
  } kern_rsp_t;

endpackage

// ----- design/blr_in_if.sv -----
`timescale 1ns / 1ps

interface blr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source(output valid, output red_in, output green_in, output blue_in,
                 input ready);
  modport sink(input valid, input red_in, input green_in, input blue_in,
               output ready);
endinterface

// ----- design/blr_out_if.sv -----
`timescale 1ns / 1ps

interface blr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [11:0] out_column;
  logic        row_done;
  logic        run_last;

  modport source(output valid, output red_out, output green_out, output blue_out,
                 output out_column, output row_done, output run_last,
                 input ready);
  modport sink(input valid, input red_out, input green_out, input blue_out,
               input out_column, input row_done, input run_last,
               output ready);
endinterface

// ----- design/blr_line_store.sv -----
`timescale 1ns / 1ps

module blr_line_store
  import blr_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  pixel_t            wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output pixel_t            rdata
);

  pixel_t mem [MAX_ROW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/blr_div.sv -----
`timescale 1ns / 1ps

module blr_div
  import blr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] q;
  logic [DIV_DW:0]   rem;
  logic [DIV_DW-1:0] den;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              done;
  logic [DIV_DW:0]   rem_sh;
  logic              fits;

  always_comb begin
    rem_sh = {rem[DIV_DW-1:0], q[DIV_NW-1]};
    fits   = rem_sh >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        q    <= req.numer;
        den  <= req.denom;
        rem  <= '0;
        cnt  <= CW'(DIV_NW);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= fits ? rem_sh - {1'b0, den} : rem_sh;
        q    <= {q[DIV_NW-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = q;

endmodule

// ----- design/blr_kernel.sv -----
`timescale 1ns / 1ps

module blr_kernel
  import blr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  kern_req_t req,
  output kern_rsp_t rsp
);

  localparam logic signed [63:0] ONE49 = 64'sd1 <<< 49;
  localparam logic signed [63:0] TWO49 = 64'sd1 <<< 50;
  localparam logic signed [63:0] HALF  = 64'sd1 <<< (KERN_SHIFT - 1);

  logic [T_W-1:0]     t1, t2;
  logic               big1, big2, big3;
  logic [2*T_W-1:0]   x2, x2b;
  logic [3*T_W-1:0]   x3;
  logic               v1, v2, v3, v4;
  logic signed [63:0] w49;
  logic signed [63:0] w49_next;
  logic signed [63:0] x3s, x2s, ts;
  logic signed [63:0] mag, wr;
  logic signed [W_W-1:0] w;

  always_comb begin
    x3s = $signed(64'(x3));
    x2s = $signed(64'(x2b) << 16);
    ts  = $signed(64'(t2) << 35);
    if (t2 < T_W'(UNIT_SCALE)) begin
      w49_next = 3 * x3s - 5 * x2s + ONE49;
    end else begin
      w49_next = 5 * x2s - x3s - ts + TWO49;
    end
    mag = w49[63] ? -w49 : w49;
    wr  = (mag + HALF) >>> KERN_SHIFT;
    if (w49[63]) begin
      wr = -wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= req.start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    t1   <= req.t;
    big1 <= req.big;
    x2   <= (2*T_W)'(req.t) * (2*T_W)'(req.t);
    t2   <= t1;
    big2 <= big1;
    x2b  <= x2;
    x3   <= (3*T_W)'(x2) * (3*T_W)'(t1);
    big3 <= big2;
    w49  <= w49_next;
    w    <= big3 ? '0 : wr[W_W-1:0];
  end

  assign rsp.done = v4;
  assign rsp.w    = w;

endmodule

// ----- design/bicubic_line_resampler.sv -----
`timescale 1ns / 1ps
// Horizontal Catmull-Rom resampler for one RGB row at a time.
// pixels_in takes source pixels in row order, one per transfer; pixels_out
// gives output pixels in column order, with row_done on the last column and
// run_last on the last output caused by an input pixel (an input may cause
// none). cfg_we/cfg_index/cfg_data write src_width and dst_width; they take
// effect at the first pixel of the next row, so write them between rows.
// One item is worked at a time; pixels_in is ready only when the block is idle.
// Row start: one divide for the step ratio.
// Equal widths: each pixel goes through DISPATCH and PASS to the output
// register unchanged; the next pixel is taken only after FINISH, at idle.
// Resampled: per output, T window taps (up to 18) each get a kernel weight;
// the single shared bit-serial divider does the tap argument (downscaling
// only) and the weight normalization. An input that causes no output goes
// through WIN_MUL and WIN_CMP to FINISH.
// Reset clears the counters, sets both widths to 1 and empties the output
// register; the line store is not cleared. A stalled receiver holds the
// output register, and the block waits for it before placing the next result.
module bicubic_line_resampler
  import blr_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [12:0]     cfg_data,
  blr_in_if.sink          pixels_in,
  blr_out_if.source       pixels_out
);

  `include "bicubic_line_resampler_defines.svh"

  typedef enum logic [3:0] {
    ST_IDLE, ST_RATIO, ST_DISPATCH, ST_PASS, ST_WIN_MUL, ST_WIN_CMP, ST_PUSH,
    ST_TAP_ARG, ST_TAP_DIV, ST_TAP_KERN, ST_NORM, ST_NORM_DIV, ST_MAC,
    ST_ROUND, ST_FINISH
  } state_t;

  state_t state;

  logic [CNT_W-1:0]  src_cfg, dst_cfg;
  logic [CNT_W-1:0]  eff_src, eff_dst;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  rc, nxt;
  logic [EMIT_W-1:0] n_emit;
  pixel_t            pix_hold;
  logic [31:0]       c;
  logic [CNT_W-1:0]  l, r;
  logic [CNT_W-1:0]  tap_s;
  logic [TAP_W-1:0]  tap_i;
  logic              emit;
  logic signed [W_W-1:0]   w_arr [TAP_MAX];
  logic signed [TOT_W-1:0] total;
  logic signed [WN_W-1:0]  wn;
  logic signed [ACC_W-1:0] acc [3];
  pixel_t            pend_pix;
  logic [11:0]       pend_col;
  logic              pend_done;
  logic              have_pend;

  logic              out_valid;
  logic [7:0]        out_red, out_green, out_blue;
  logic [11:0]       out_col;
  logic              out_done, out_last;

  logic              in_accept, out_free;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  kern_req_t         kern_req;
  kern_rsp_t         kern_rsp;
  pixel_t            rd_pix;

  logic [CNT_W-1:0]  s_c, d_c, lo_c, hi_c;
  logic [15:0]       hi16;
  logic [STEP_W-1:0] fs;
  logic              fs_unit;
  logic [33:0]       prod;
  logic [34:0]       lv, rv;
  logic [18:0]       l_a, r_a, l_w, r_w, c_hi;
  logic              emit_w;
  logic signed [33:0] dd;
  logic [31:0]       ad;
  logic signed [W_W-1:0] w_sel;
  logic [W_W-1:0]    w_mag;
  logic [TOT_W-1:0]  tot_mag;
  logic              norm_neg;
  logic signed [WN_W-1:0] wn_div;
  logic signed [ACC_W-1:0] acc_next [3];
  logic [7:0]        ch_out [3];
  logic signed [ACC_W-1:0] rpos;
  logic [CNT_W-1:0]  tap_s_next;

  assign in_accept = pixels_in.valid && pixels_in.ready;
  assign out_free  = !out_valid || pixels_out.ready;
  assign pixels_in.ready = (state == ST_IDLE);

  always_comb begin
    s_c = src_cfg;
    if (s_c == '0) begin
      s_c = CNT_W'(1);
    end else if (s_c > CNT_W'(MAX_ROW)) begin
      s_c = CNT_W'(MAX_ROW);
    end
    lo_c = CNT_W'((s_c + CNT_W'(MAX_DOWNSCALE - 1)) / MAX_DOWNSCALE);
    hi16 = 16'(s_c) * 16'(MAX_UPSCALE);
    hi_c = (hi16 > 16'(MAX_ROW)) ? CNT_W'(MAX_ROW) : hi16[CNT_W-1:0];
    d_c  = dst_cfg;
    if (d_c < lo_c) begin
      d_c = lo_c;
    end else if (d_c > hi_c) begin
      d_c = hi_c;
    end
  end

  always_comb begin
    fs_unit = step <= STEP_W'(UNIT_SCALE);
    fs      = fs_unit ? STEP_W'(UNIT_SCALE) : step;
    prod    = 34'({nxt, 1'b1}) * 34'(step);

    lv   = 35'(c) - 35'({fs, 1'b0}) + 35'(UNIT_SCALE / 2);
    rv   = 35'(c) + 35'({fs, 1'b0}) + 35'(UNIT_SCALE / 2);
    l_a  = (lv[34] || lv == '0) ? '0 : lv[34:16];
    r_a  = rv[34:16];
    if (r_a > 19'(eff_src)) begin
      r_a = 19'(eff_src);
    end
    c_hi = 19'(c[31:16]);
    l_w  = l_a;
    r_w  = r_a;
    if (r_a <= l_a) begin
      l_w = (c_hi > 19'(eff_src - 1'b1)) ? 19'(eff_src - 1'b1) : c_hi;
      r_w = l_w + 1'b1;
    end
    if (r_w - l_w > 19'(TAP_MAX)) begin
      r_w = l_w + 19'(TAP_MAX);
    end
    emit_w = (nxt < eff_dst) && (n_emit < EMIT_W'(RESULT_MAX)) &&
             !((r_w > 19'(rc)) && (rc < eff_src));

    dd = $signed(34'({tap_s, 1'b1, 15'b0})) - $signed(34'(c));
    ad = dd[33] ? 32'(-dd) : 32'(dd);

    w_sel    = w_arr[tap_i];
    w_mag    = w_sel[W_W-1] ? W_W'(-w_sel) : W_W'(w_sel);
    tot_mag  = total[TOT_W-1] ? TOT_W'(-total) : TOT_W'(total);
    norm_neg = w_sel[W_W-1] ^ total[TOT_W-1];
    wn_div   = norm_neg ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
    tap_s_next = tap_s + 1'b1;

    for (int k = 0; k < 3; k++) begin
      acc_next[k] = acc[k] + 64'(wn) * 64'($signed({1'b0, rd_pix[8*k +: 8]}));
      rpos = (acc[k] + (64'sd1 <<< (WEIGHT_BITS - 1))) >>> WEIGHT_BITS;
      if (acc[k][ACC_W-1]) begin
        ch_out[k] = 8'd0;
      end else if (rpos > 64'sd255) begin
        ch_out[k] = 8'd255;
      end else begin
        ch_out[k] = rpos[7:0];
      end
    end
  end

  always_comb begin
    div_req = '0;
    case (state)
      ST_IDLE: begin
        div_req.start = in_accept && (rc == '0);
        div_req.numer = (DIV_NW'(s_c) << 16) + DIV_NW'(d_c >> 1);
        div_req.denom = DIV_DW'(d_c);
      end
      ST_TAP_ARG: begin
        div_req.start = !fs_unit;
        div_req.numer = DIV_NW'(ad) << 16;
        div_req.denom = DIV_DW'(fs);
      end
      ST_NORM: begin
        div_req.start = (total != '0);
        div_req.numer = (DIV_NW'(w_mag) << WEIGHT_BITS) + DIV_NW'(tot_mag >> 1);
        div_req.denom = DIV_DW'(tot_mag);
      end
      default: div_req = '0;
    endcase
  end

  always_comb begin
    kern_req.start = ((state == ST_TAP_ARG) && fs_unit) ||
                     ((state == ST_TAP_DIV) && div_rsp.done);
    kern_req.t     = fs_unit ? ad[T_W-1:0] : div_rsp.quot[T_W-1:0];
    kern_req.big   = fs_unit ? (|ad[31:T_W]) : (|div_rsp.quot[DIV_NW-1:T_W]);
  end

  blr_line_store u_store (
    .clk  (clk),
    .we   (in_accept),
    .waddr(rc[ADDR_W-1:0]),
    .wdata({pixels_in.blue_in, pixels_in.green_in, pixels_in.red_in}),
    .re   (state == ST_NORM),
    .raddr(tap_s[ADDR_W-1:0]),
    .rdata(rd_pix)
  );

  blr_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  blr_kernel u_kernel (
    .clk(clk),
    .rst(rst),
    .req(kern_req),
    .rsp(kern_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      src_cfg   <= CNT_W'(1);
      dst_cfg   <= CNT_W'(1);
      eff_src   <= CNT_W'(1);
      eff_dst   <= CNT_W'(1);
      step      <= '0;
      rc        <= '0;
      nxt       <= '0;
      n_emit    <= '0;
      have_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SRC_WIDTH: src_cfg <= cfg_data;
          REG_DST_WIDTH: dst_cfg <= cfg_data;
        endcase
      end
      if (out_valid && pixels_out.ready && !(state inside {ST_PASS, ST_PUSH})) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            pix_hold  <= {pixels_in.blue_in, pixels_in.green_in, pixels_in.red_in};
            rc        <= rc + 1'b1;
            n_emit    <= '0;
            have_pend <= 1'b0;
            if (rc == '0) begin
              eff_src <= s_c;
              eff_dst <= d_c;
              nxt     <= '0;
              state   <= ST_RATIO;
            end else begin
              state   <= ST_DISPATCH;
            end
          end
        end
        ST_RATIO: begin
          if (div_rsp.done) begin
            step  <= div_rsp.quot[STEP_W-1:0];
            state <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          if (eff_src == eff_dst) begin
            pend_pix  <= pix_hold;
            pend_col  <= 12'(rc - 1'b1);
            pend_done <= rc >= eff_src;
            state     <= ST_PASS;
          end else begin
            state     <= ST_WIN_MUL;
          end
        end
        ST_PASS: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_red   <= pend_pix[7:0];
            out_green <= pend_pix[15:8];
            out_blue  <= pend_pix[23:16];
            out_col   <= pend_col;
            out_done  <= pend_done;
            out_last  <= 1'b1;
            state     <= ST_FINISH;
          end else begin
            out_valid <= out_valid;
          end
        end
        ST_WIN_MUL: begin
          c     <= prod[32:1];
          state <= ST_WIN_CMP;
        end
        ST_WIN_CMP: begin
          l     <= l_w[CNT_W-1:0];
          r     <= r_w[CNT_W-1:0];
          tap_s <= l_w[CNT_W-1:0];
          tap_i <= '0;
          total <= '0;
          emit  <= emit_w;
          for (int k = 0; k < 3; k++) begin
            acc[k] <= '0;
          end
          if (have_pend) begin
            state <= ST_PUSH;
          end else if (emit_w) begin
            state <= ST_TAP_ARG;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_red   <= pend_pix[7:0];
            out_green <= pend_pix[15:8];
            out_blue  <= pend_pix[23:16];
            out_col   <= pend_col;
            out_done  <= pend_done;
            out_last  <= !emit;
            have_pend <= 1'b0;
            state     <= emit ? ST_TAP_ARG : ST_FINISH;
          end
        end
        ST_TAP_ARG: begin
          state <= fs_unit ? ST_TAP_KERN : ST_TAP_DIV;
        end
        ST_TAP_DIV: begin
          if (div_rsp.done) begin
            state <= ST_TAP_KERN;
          end
        end
        ST_TAP_KERN: begin
          if (kern_rsp.done) begin
            w_arr[tap_i] <= kern_rsp.w;
            total        <= total + TOT_W'(kern_rsp.w);
            if (tap_s_next == r) begin
              tap_s <= l;
              tap_i <= '0;
              state <= ST_NORM;
            end else begin
              tap_s <= tap_s_next;
              tap_i <= tap_i + 1'b1;
              state <= ST_TAP_ARG;
            end
          end
        end
        ST_NORM: begin
          if (total == '0) begin
            wn    <= WN_W'(w_sel);
            state <= ST_MAC;
          end else begin
            state <= ST_NORM_DIV;
          end
        end
        ST_NORM_DIV: begin
          if (div_rsp.done) begin
            wn    <= wn_div;
            state <= ST_MAC;
          end
        end
        ST_MAC: begin
          for (int k = 0; k < 3; k++) begin
            acc[k] <= acc_next[k];
          end
          if (tap_s_next == r) begin
            state <= ST_ROUND;
          end else begin
            tap_s <= tap_s_next;
            tap_i <= tap_i + 1'b1;
            state <= ST_NORM;
          end
        end
        ST_ROUND: begin
          pend_pix  <= {ch_out[2], ch_out[1], ch_out[0]};
          pend_col  <= nxt[11:0];
          pend_done <= nxt == eff_dst - 1'b1;
          have_pend <= 1'b1;
          nxt       <= nxt + 1'b1;
          n_emit    <= n_emit + 1'b1;
          state     <= ST_WIN_MUL;
        end
        ST_FINISH: begin
          if (rc >= eff_src) begin
            rc  <= '0;
            nxt <= '0;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign pixels_out.valid      = out_valid;
  assign pixels_out.red_out    = out_red;
  assign pixels_out.green_out  = out_green;
  assign pixels_out.blue_out   = out_blue;
  assign pixels_out.out_column = out_col;
  assign pixels_out.row_done   = out_done;
  assign pixels_out.run_last   = out_last;

  `BLR_ASSERT_IMP(a_idle_count, state == ST_IDLE, rc < eff_src, "row count past width while idle")
  `BLR_ASSERT_IMP(a_emit_bound, 1'b1, n_emit <= EMIT_W'(RESULT_MAX), "too many results for one pixel")
  `BLR_ASSERT_NXT(a_accept_busy, in_accept, state != ST_IDLE, "idle right after a transfer")

endmodule
